// File: src/mfs_pkg.sv
// ----------------------------------------------------------------------------
// mfs_pkg
// Shared types and codes of the multilevel feedback scheduler.
// ----------------------------------------------------------------------------
package mfs_pkg;

    localparam int PID_W   = 16;
    localparam int ORDER_W = 32;
    localparam int REQ_W   = 3;
    localparam int STAT_W  = 2;
    localparam int TSTATE_W = 2;
    localparam int IN_W    = 24;
    localparam int OUT_W   = 56;

    // request codes
    localparam logic [REQ_W-1:0] REQ_TICK    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_CREATE  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_KILL    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_BLOCK   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_UNBLOCK = 3'd4;
    localparam logic [REQ_W-1:0] REQ_EXIT    = 3'd5;

    // task states
    localparam logic [TSTATE_W-1:0] TS_READY   = 2'd0;
    localparam logic [TSTATE_W-1:0] TS_RUNNING = 2'd1;
    localparam logic [TSTATE_W-1:0] TS_BLOCKED = 2'd2;
    localparam logic [TSTATE_W-1:0] TS_EXITED  = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_INVALID  = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic rd_run;
        logic fix;
        logic scan_issue;
        logic rd_found;
        logic apply;
        logic out_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [REQ_W-1:0] req_in;
        logic             scan_last;
    } dp_sts_t;

endpackage

// File: src/mfs_ram.sv
// ----------------------------------------------------------------------------
// mfs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/mfs_ctrl.sv
// ----------------------------------------------------------------------------
// mfs_ctrl
// Request sequencer: steps each request through read, scan and apply phases
// and owns the result handshake.
// ----------------------------------------------------------------------------
module mfs_ctrl
    import mfs_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    output dp_cmd_t cmd,
    input  dp_sts_t sts
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FIXRD = 3'd1;
    localparam logic [2:0] S_FIX   = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_APRD  = 3'd5;
    localparam logic [2:0] S_APPLY = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    // sequence the phases of one request
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd.capture = 1'b1;
                    case (sts.req_in)
                        REQ_TICK:    state_next = S_FIXRD;
                        REQ_CREATE,
                        REQ_KILL,
                        REQ_BLOCK,
                        REQ_UNBLOCK: state_next = S_SCAN;
                        REQ_EXIT:    state_next = S_APRD;
                        default:     state_next = S_DONE;
                    endcase
                end
            end
            S_FIXRD: begin
                cmd.rd_run = 1'b1;
                state_next = S_FIX;
            end
            S_FIX: begin
                cmd.fix    = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN: begin
                cmd.scan_issue = 1'b1;
                if (sts.scan_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next = S_APRD;
            end
            S_APRD: begin
                cmd.rd_found = 1'b1;
                state_next   = S_APPLY;
            end
            S_APPLY: begin
                cmd.apply  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // hold the result until the transfer completes
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_idle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && !s_tvalid) |=> state_reg == S_IDLE)
        else $error("left idle without a transfer");
    a_scan_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN && sts.scan_last) |=> state_reg == S_DRAIN)
        else $error("scan did not end after last slot");
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> out_valid_reg)
        else $error("result not presented after load");

endmodule

// File: src/mfs_dp.sv
// ----------------------------------------------------------------------------
// mfs_dp
// Scheduler datapath: task table, scan comparator, request application
// and result register.
// ----------------------------------------------------------------------------
module mfs_dp
    import mfs_pkg::*;
#(
    parameter int LEVELS    = 4,
    parameter int MAX_TASKS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [IN_W-1:0]  s_tdata,
    output logic [OUT_W-1:0] m_tdata,
    input  dp_cmd_t          cmd,
    output dp_sts_t          sts
);

    localparam int IDX_W  = $clog2(MAX_TASKS);
    localparam int LVL_W  = $clog2(LEVELS);
    localparam int WORD_W = 1 + ORDER_W + LVL_W + TSTATE_W + PID_W;
    localparam int ST_LO  = PID_W;
    localparam int LV_LO  = PID_W + TSTATE_W;
    localparam int OR_LO  = LV_LO + LVL_W;
    localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(LEVELS - 1);

    // request
    logic [REQ_W-1:0]   req_reg;
    logic [PID_W-1:0]   tpid_reg;
    logic               fgin_reg;
    // scheduler state
    logic [MAX_TASKS-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0]   run_slot_reg, run_slot_next;
    logic               run_idle_reg, run_idle_next;
    logic [PID_W-1:0]   run_pid_reg, run_pid_next;
    logic [LVL_W-1:0]   run_lvl_reg, run_lvl_next;
    logic [PID_W-1:0]   fg_task_reg, fg_task_next;
    logic [PID_W-1:0]   next_pid_reg, next_pid_next;
    logic [ORDER_W-1:0] order_reg, order_next;
    // scan
    logic [IDX_W-1:0]   scan_idx_reg;
    logic               cmp_en_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;
    logic               found_reg;
    logic [IDX_W-1:0]   found_idx_reg;
    logic [LVL_W-1:0]   best_lvl_reg;
    logic [ORDER_W-1:0] best_order_reg;
    // outcome
    logic [STAT_W-1:0]  status_reg, status_next;
    logic               created_reg, created_next;
    logic [PID_W-1:0]   cpid_reg, cpid_next;
    logic [OUT_W-1:0]   out_reg;

    // table port
    logic               we;
    logic [IDX_W-1:0]   waddr, raddr;
    logic [WORD_W-1:0]  wdata, rdata;
    logic [PID_W-1:0]   rd_pid;
    logic [TSTATE_W-1:0] rd_st;
    logic [LVL_W-1:0]   rd_lvl;
    logic [ORDER_W-1:0] rd_order;
    logic               rd_fg;
    logic               cand, better;
    logic [TSTATE_W-1:0] want_st;
    logic [PID_W-1:0]   pid_inc, runpid;

    assign rd_pid   = rdata[PID_W-1:0];
    assign rd_st    = rdata[ST_LO +: TSTATE_W];
    assign rd_lvl   = rdata[LV_LO +: LVL_W];
    assign rd_order = rdata[OR_LO +: ORDER_W];
    assign rd_fg    = rdata[WORD_W-1];

    assign sts.req_in    = s_tdata[REQ_W-1:0];
    assign sts.scan_last = (scan_idx_reg == IDX_W'(MAX_TASKS - 1));

    mfs_ram #(.WIDTH(WORD_W), .DEPTH(MAX_TASKS)) u_table (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // select the table read address
    always_comb begin
        raddr = found_idx_reg;
        if (cmd.rd_run) begin
            raddr = run_slot_reg;
        end else if (cmd.scan_issue) begin
            raddr = scan_idx_reg;
        end
    end

    // scan candidate test and ranking
    always_comb begin
        cand   = 1'b0;
        better = !found_reg;
        case (req_reg)
            REQ_CREATE: cand = !valid_reg[cmp_idx_reg];
            REQ_TICK: begin
                cand   = valid_reg[cmp_idx_reg] && (rd_st != TS_BLOCKED);
                better = !found_reg || (rd_lvl < best_lvl_reg) ||
                         (rd_lvl == best_lvl_reg && rd_order > best_order_reg);
            end
            default: cand = valid_reg[cmp_idx_reg] && (rd_pid == tpid_reg) &&
                            (tpid_reg != '0);
        endcase
    end

    assign pid_inc = next_pid_reg + PID_W'(1);
    assign want_st = (req_reg == REQ_BLOCK) ? TS_BLOCKED : TS_READY;

    // tick fix-up of the running task and application of the request
    always_comb begin
        valid_next    = valid_reg;
        run_slot_next = run_slot_reg;
        run_idle_next = run_idle_reg;
        run_pid_next  = run_pid_reg;
        run_lvl_next  = run_lvl_reg;
        fg_task_next  = fg_task_reg;
        next_pid_next = next_pid_reg;
        order_next    = order_reg;
        status_next   = status_reg;
        created_next  = created_reg;
        cpid_next     = cpid_reg;
        we            = 1'b0;
        waddr         = found_idx_reg;
        wdata         = rdata;
        if (cmd.capture) begin
            status_next  = ST_OK;
            created_next = 1'b0;
        end
        if (cmd.fix && !run_idle_reg && valid_reg[run_slot_reg]) begin
            waddr = run_slot_reg;
            case (rd_st)
                TS_EXITED: valid_next[run_slot_reg] = 1'b0;
                TS_RUNNING: begin
                    we = 1'b1;
                    wdata[ST_LO +: TSTATE_W] = TS_READY;
                    if (rd_lvl < LVL_TOP) begin
                        wdata[LV_LO +: LVL_W]   = rd_lvl + LVL_W'(1);
                        wdata[OR_LO +: ORDER_W] = order_reg;
                        order_next = order_reg + ORDER_W'(1);
                    end
                end
                TS_BLOCKED: begin
                    if (rd_lvl != '0) begin
                        we = 1'b1;
                        wdata[LV_LO +: LVL_W]   = rd_lvl - LVL_W'(1);
                        wdata[OR_LO +: ORDER_W] = order_reg;
                        order_next = order_reg + ORDER_W'(1);
                    end
                end
                default: ;
            endcase
        end
        if (cmd.apply) begin
            case (req_reg)
                REQ_TICK: begin
                    if (found_reg) begin
                        we = 1'b1;
                        wdata[ST_LO +: TSTATE_W] = TS_RUNNING;
                        run_slot_next = found_idx_reg;
                        run_idle_next = 1'b0;
                        run_pid_next  = rd_pid;
                        run_lvl_next  = rd_lvl;
                        if (rd_fg) begin
                            fg_task_next = rd_pid;
                        end
                    end else begin
                        run_idle_next = 1'b1;
                    end
                end
                REQ_CREATE: begin
                    if (!found_reg) begin
                        status_next = ST_FULL;
                    end else begin
                        we = 1'b1;
                        wdata = {fgin_reg, order_reg, LVL_W'(0), TS_READY, next_pid_reg};
                        valid_next[found_idx_reg] = 1'b1;
                        order_next    = order_reg + ORDER_W'(1);
                        created_next  = 1'b1;
                        cpid_next     = next_pid_reg;
                        next_pid_next = (pid_inc == '0) ? PID_W'(1) : pid_inc;
                    end
                end
                REQ_KILL: begin
                    if (!found_reg) begin
                        status_next = ST_NOTFOUND;
                    end else begin
                        valid_next[found_idx_reg] = 1'b0;
                        if (!run_idle_reg && run_slot_reg == found_idx_reg) begin
                            run_idle_next = 1'b1;
                        end
                    end
                end
                REQ_BLOCK,
                REQ_UNBLOCK: begin
                    if (!found_reg) begin
                        status_next = ST_NOTFOUND;
                    end else if (rd_st == want_st) begin
                        status_next = ST_OK;
                    end else if (rd_st == TS_READY || rd_st == TS_RUNNING ||
                                 (rd_st == TS_BLOCKED && want_st == TS_READY)) begin
                        we = 1'b1;
                        wdata[ST_LO +: TSTATE_W] = want_st;
                    end else begin
                        status_next = ST_INVALID;
                    end
                end
                REQ_EXIT: begin
                    if (!found_reg) begin
                        status_next = ST_NOTFOUND;
                    end else begin
                        we = 1'b1;
                        wdata[ST_LO +: TSTATE_W] = TS_EXITED;
                    end
                end
                default: ;
            endcase
        end
    end

    assign runpid = run_idle_reg ? '0 : run_pid_reg;

    // request, scan and result registers
    always_ff @(posedge aclk) begin
        cmp_idx_reg <= scan_idx_reg;
        status_reg  <= status_next;
        created_reg <= created_next;
        cpid_reg    <= cpid_next;
        run_pid_reg <= run_pid_next;
        run_lvl_reg <= run_lvl_next;
        if (cmd.capture) begin
            req_reg   <= s_tdata[REQ_W-1:0];
            tpid_reg  <= s_tdata[REQ_W +: PID_W];
            fgin_reg  <= s_tdata[REQ_W + PID_W];
            scan_idx_reg  <= '0;
            found_idx_reg <= run_slot_reg;
        end else if (cmd.scan_issue) begin
            scan_idx_reg <= scan_idx_reg + IDX_W'(1);
        end
        if (cmp_en_reg && cand && better) begin
            found_idx_reg  <= cmp_idx_reg;
            best_lvl_reg   <= rd_lvl;
            best_order_reg <= rd_order;
        end
        if (cmd.out_load) begin
            out_reg <= {3'b000, run_idle_reg, fg_task_reg, STAT_W'(run_lvl_reg & {LVL_W{!run_idle_reg}}),
                        runpid, created_reg ? cpid_reg : runpid, status_reg};
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            run_slot_reg <= '0;
            run_idle_reg <= 1'b1;
            fg_task_reg  <= '0;
            next_pid_reg <= PID_W'(1);
            order_reg    <= '0;
            cmp_en_reg   <= 1'b0;
            found_reg    <= 1'b0;
        end else begin
            valid_reg    <= valid_next;
            run_slot_reg <= run_slot_next;
            run_idle_reg <= run_idle_next;
            fg_task_reg  <= fg_task_next;
            next_pid_reg <= next_pid_next;
            order_reg    <= order_next;
            cmp_en_reg   <= cmd.scan_issue;
            if (cmd.capture) begin
                found_reg <= (s_tdata[REQ_W-1:0] == REQ_EXIT) && !run_idle_reg;
            end else if (cmp_en_reg && cand) begin
                found_reg <= 1'b1;
            end
        end
    end

    assign m_tdata = out_reg;

    a_tick_pick: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.apply && req_reg == REQ_TICK && found_reg) |=> !run_idle_reg)
        else $error("picked task not running");
    a_created_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        created_reg |-> status_reg == ST_OK)
        else $error("create marked done with error status");
    a_next_pid: assert property (@(posedge aclk) disable iff (!aresetn)
        next_pid_reg != '0)
        else $error("next pid reached zero");

endmodule

// File: src/multilevel_feedback_scheduler_unit.sv
// Multilevel feedback queue scheduler over a table of MAX_TASKS task slots.
// Each request (tick, create, kill, block, unblock, exit) returns one result
// with status, the pid concerned, running pid and level, foreground pid and
// idle flag. One request is handled at a time. Create, kill, block and
// unblock scan the table, one table slot read per cycle, followed by a drain,
// a read and an apply step. A tick first reads and updates the running task
// before the scan. Exit skips the scan and goes to the read and apply steps;
// an unused code goes straight to the result load, which waits until the
// previous result has been taken.
// ----------------------------------------------------------------------------
// multilevel_feedback_scheduler_unit
// Top level: joins the request sequencer and the scheduler datapath.
// ----------------------------------------------------------------------------
module multilevel_feedback_scheduler_unit
    import mfs_pkg::*;
#(
    parameter int LEVELS    = 4,
    parameter int MAX_TASKS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // req_type[2:0], target_pid[18:3], is_foreground[19], zero fill
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // status[1:0], result_pid[17:2], running_pid[33:18], running_level[35:34],
    // foreground_pid[51:36], idle[52], zero fill
    output logic [OUT_W-1:0] m_tdata
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    mfs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    mfs_dp #(.LEVELS(LEVELS), .MAX_TASKS(MAX_TASKS)) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule
